// ===== rtl/serial_command_frame_receiver_core_macros.svh =====
// Assertion macros for the serial command frame receiver.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH

// check outside reset
`define SCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds across reset
`define SCFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/scfr_pkg.sv =====
// Shared types and constants for the serial command frame receiver.
// No dependencies.
`default_nettype none

package scfr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int POS_W       = 3;
  localparam int PAY_N       = FRAME_BYTES - 3;

  localparam logic [7:0] HDR_FIRST  = 8'h3E;
  localparam logic [7:0] HDR_SECOND = 8'h04;

  // frame positions
  localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PAYLOAD0 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHK_HI   = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CHK_LO   = POS_W'(FRAME_BYTES - 1);

  // item and result kinds
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // register select (paddr[2])
  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_OPEN_MODE = 1'b1;

  localparam logic [15:0] TIMEOUT_RST = 16'd160;

  typedef struct packed {
    logic       done;
    logic       good;
    logic [7:0] mode;
    logic [7:0] night;
    logic [7:0] speed;
    logic [7:0] brake;
  } frame_rpt_t;

  typedef struct packed {
    logic       lost;
    logic       safe;
    logic [1:0] ctl_mode;
  } link_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scfr_frame_parser.sv =====
// Frame parser: header hunt, payload capture, checksum and command latch.
// Depends on scfr_pkg.
`default_nettype none

module scfr_frame_parser
  import scfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_vld,   // byte word waiting in the input register
  input  wire logic       step_en,    // that word moves on this edge
  input  wire logic [7:0] rx_byte,
  output frame_rpt_t      rpt,
  output logic [7:0]      latched_speed,
  output logic [7:0]      latched_brake
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt, sum_add;
  logic [7:0]       payload_r [PAY_N];
  logic [7:0]       speed_r, brake_r;
  logic [15:0]      chk;

  assign sum_add = sum_r + {8'h00, rx_byte};
  assign chk     = {payload_r[PAY_N-1], rx_byte};

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    rpt.done  = 1'b0;
    rpt.good  = 1'b0;
    rpt.mode  = payload_r[0];
    rpt.night = payload_r[1];
    rpt.speed = payload_r[2];
    rpt.brake = payload_r[3];
    if (byte_vld) begin
      case (pos_r)
        POS_HUNT: begin
          if (rx_byte == HDR_FIRST) begin
            sum_nxt = {8'h00, rx_byte};
            pos_nxt = POS_HDR2;
          end
        end
        POS_HDR2: begin
          if (rx_byte == HDR_SECOND) begin
            sum_nxt = sum_add;
            pos_nxt = POS_PAYLOAD0;
          end else begin
            // bad second byte is not retried as a first byte
            sum_nxt = '0;
            pos_nxt = POS_HUNT;
          end
        end
        POS_CHK_LO: begin
          rpt.done = 1'b1;
          rpt.good = (chk == sum_r);
          sum_nxt  = '0;
          pos_nxt  = POS_HUNT;
        end
        default: begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r != POS_CHK_HI) sum_nxt = sum_add;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      sum_r   <= '0;
      speed_r <= '0;
      brake_r <= '0;
    end else if (step_en && byte_vld) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (rpt.done && rpt.good) begin
        speed_r <= payload_r[2];
        brake_r <= payload_r[3];
      end
    end
  end

  for (genvar i = 0; i < PAY_N; i++) begin : g_pay
    always_ff @(posedge clk) begin
      if (step_en && byte_vld && pos_r == POS_W'(int'(POS_PAYLOAD0) + i))
        payload_r[i] <= rx_byte;
    end
  end

  assign latched_speed = speed_r;
  assign latched_brake = brake_r;

endmodule

`default_nettype wire

// ===== rtl/scfr_link_mon.sv =====
// Serial link monitor: saturating silence counter and lost-link flag.
// Depends on scfr_pkg.
`default_nettype none

module scfr_link_mon
  import scfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic        tick_vld,
  input  wire logic        frame_ok,     // good frame completes
  input  wire logic        adc_fault,
  input  wire logic [1:0]  req_mode,
  input  wire logic [15:0] timeout_lim,
  input  wire logic [1:0]  safe_mode,
  output link_stat_t       stat
);

  logic [15:0] cnt_r, cnt_nxt;
  logic        lost_r, lost_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    lost_nxt = lost_r;
    if (tick_vld) begin
      if (cnt_r >= timeout_lim) begin
        lost_nxt = 1'b1;
        cnt_nxt  = timeout_lim;
      end else begin
        cnt_nxt = cnt_r + 16'd1;
      end
    end else if (frame_ok) begin
      lost_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lost_r <= 1'b0;
    end else if (step_en) begin
      cnt_r  <= cnt_nxt;
      lost_r <= lost_nxt;
    end
  end

  assign stat.lost     = lost_nxt;
  assign stat.safe     = lost_nxt | adc_fault;
  assign stat.ctl_mode = stat.safe ? safe_mode : req_mode;

endmodule

`default_nettype wire

// ===== rtl/scfr_cfg_regs.sv =====
// APB-style configuration registers: serial timeout and open mode code.
// Depends on scfr_pkg.
`default_nettype none

module scfr_cfg_regs
  import scfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      timeout_lim,
  output logic [1:0]       safe_mode
);

  logic [15:0] timeout_r;
  logic [1:0]  safe_mode_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      safe_mode_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TIMEOUT:   timeout_r   <= pwdata[15:0];
        REG_OPEN_MODE: safe_mode_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT:   prdata = {16'h0000, timeout_r};
      REG_OPEN_MODE: prdata = {30'h0, safe_mode_r};
      default:       prdata = '0;
    endcase
  end

  assign timeout_lim = timeout_r;
  assign safe_mode   = safe_mode_r;

endmodule

`default_nettype wire

// ===== rtl/serial_command_frame_receiver_core.sv =====
// Serial command frame receiver, top level.
// Each word passes the input register, one pass of logic and the result register.
// Throughput: one word per cycle while the result register is free or being drained.
// Input ready stays high while the result register is free or being drained.
// Reset (rst_n, synchronous): parser hunts the header, counters and latches clear,
// timeout register returns to 160 and open mode to 0.
`default_nettype none
`include "serial_command_frame_receiver_core_macros.svh"

module serial_command_frame_receiver_core
  import scfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte[7:0], adc_fault[8], requested_mode[10:9]
  input  wire logic        in_tuser,   // op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // frame_good[0], ride_mode[8:1], night_light[16:9], speed_cmd[24:17],
  // brake_cmd[32:25], control_mode[34:33], timeout_flag[35]
  output logic [39:0]      out_tdata,
  output logic             out_tuser,  // result_kind
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic        in_vld_r;
  logic        op_r;
  logic [7:0]  byte_r;
  logic        adc_r;
  logic [1:0]  req_r;

  logic        out_vld_r;
  logic        kind_r;
  logic [35:0] res_r, res_nxt;

  logic        byte_vld, tick_vld, has_result, out_free, advance;
  logic [15:0] timeout_lim;
  logic [1:0]  safe_mode;
  logic [7:0]  lat_speed, lat_brake;
  frame_rpt_t  rpt;
  link_stat_t  stat;

  scfr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .timeout_lim (timeout_lim),
    .safe_mode   (safe_mode)
  );

  assign byte_vld   = in_vld_r && (op_r == OP_BYTE);
  assign tick_vld   = in_vld_r && (op_r == OP_TICK);
  assign has_result = tick_vld || rpt.done;
  assign out_free   = !out_vld_r || out_tready;
  // a byte word with no result never waits on the output side
  assign advance    = in_vld_r && (!has_result || out_free);
  assign in_tready  = !in_vld_r || advance;

  scfr_frame_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_vld      (byte_vld),
    .step_en       (advance),
    .rx_byte       (byte_r),
    .rpt           (rpt),
    .latched_speed (lat_speed),
    .latched_brake (lat_brake)
  );

  scfr_link_mon u_link (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .tick_vld    (tick_vld),
    .frame_ok    (rpt.done && rpt.good),
    .adc_fault   (adc_r),
    .req_mode    (req_r),
    .timeout_lim (timeout_lim),
    .safe_mode   (safe_mode),
    .stat        (stat)
  );

  always_comb begin
    if (tick_vld) begin
      res_nxt = {stat.lost, stat.ctl_mode,
                 stat.safe ? 8'h00 : lat_brake,
                 stat.safe ? 8'h00 : lat_speed,
                 8'h00, 8'h00, 1'b0};
    end else begin
      res_nxt = {stat.lost, 2'b00, rpt.brake, rpt.speed, rpt.night, rpt.mode, rpt.good};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata[7:0];
      adc_r  <= in_tdata[8];
      req_r  <= in_tdata[10:9];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && has_result) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      kind_r <= tick_vld ? KIND_TICK : KIND_FRAME;
      res_r  <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {4'h0, res_r};

  `SCFR_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_vld_r, "result valid after reset")
  `SCFR_ASSERT(a_good_frame_clears_flag,
    out_tvalid && out_tuser == KIND_FRAME && out_tdata[0] |-> !out_tdata[35],
    "good frame report with timeout flag set")
  `SCFR_ASSERT(a_safe_tick_zero_cmd,
    out_tvalid && out_tuser == KIND_TICK && out_tdata[35] |-> out_tdata[32:17] == 16'h0000,
    "lost-link tick report carries commands")
  `SCFR_ASSERT(a_frame_no_ctl_mode,
    out_tvalid && out_tuser == KIND_FRAME |-> out_tdata[34:33] == 2'b00,
    "frame report carries control mode")

endmodule

`default_nettype wire
